// ----- rtl/dat_pkg.sv -----
// Shared types and constants for the deadline alarm table.
package dat_pkg;

	localparam int DEF_SLOTS        = 32;
	localparam int DEF_TIME_BITS    = 48;
	localparam int DEF_HANDLER_BITS = 8;

	localparam int ACTION_W = 2;
	localparam int KIND_W   = 2;
	localparam int CFG_W    = 20;

	localparam logic [CFG_W-1:0] PAST_DUE_RESET = CFG_W'(10);

	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_CANCEL = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CHECK  = 2'd2;

	typedef enum logic [KIND_W-1:0] {
		KIND_FIRED    = 2'd0,
		KIND_UPDATE   = 2'd1,
		KIND_FULL     = 2'd2,
		KIND_NOTFOUND = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		SC_FREE     = 3'd0,
		SC_MATCH    = 3'd1,
		SC_MIN_ALL  = 3'd2,
		SC_MIN_LIVE = 3'd3,
		SC_DUE      = 3'd4
	} scan_mode_t;

	typedef struct packed {
		logic       load;
		logic       scan_start;
		scan_mode_t scan_mode;
		logic       write_slot;
		logic       clear_slot;
		logic       calc_delay;
		logic       emit;
		kind_t      emit_kind;
		logic       emit_last;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic scan_hit;
		logic can_emit;
	} sts_t;

endpackage

// ----- rtl/deadline_alarm_table.sv -----
// Deadline alarm table top level: controller plus datapath.
//
//   channel   signals                                         direction
//   in        in_valid/in_ready, action, deadline,            request in
//             handler_id, now_time
//   out       out_valid/out_ready, kind, fired_handler,       results out
//             alarm_armed, alarm_delay, last
//   cfg       cfg_we, cfg_wdata (past-due delay)              write only
//
// Every table pass reads one slot a cycle. Insert, cancel or a check that fires
// nothing takes two passes; a check that fires k entries takes k+2 passes.
// Reset clears the occupancy flags at once; there is no clearing pass.
// A stalled out_ready holds the output register and halts the sequence; a new
// request is taken once the final result sits in the output register.
module deadline_alarm_table import dat_pkg::*; #(
	parameter int SLOTS        = DEF_SLOTS,
	parameter int TIME_BITS    = DEF_TIME_BITS,
	parameter int HANDLER_BITS = DEF_HANDLER_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_W-1:0]        cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [ACTION_W-1:0]     action,
	input  logic [TIME_BITS-1:0]    deadline,
	input  logic [HANDLER_BITS-1:0] handler_id,
	input  logic [TIME_BITS-1:0]    now_time,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [KIND_W-1:0]       kind,
	output logic [HANDLER_BITS-1:0] fired_handler,
	output logic                    alarm_armed,
	output logic [TIME_BITS-1:0]    alarm_delay,
	output logic                    last
);

	cmd_t cmd;
	sts_t sts;

	dat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.sts      (sts),
		.cmd      (cmd)
	);

	dat_dpath #(
		.SLOTS        (SLOTS),
		.TIME_BITS    (TIME_BITS),
		.HANDLER_BITS (HANDLER_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.deadline      (deadline),
		.handler_id    (handler_id),
		.now_time      (now_time),
		.cmd           (cmd),
		.sts           (sts),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.kind          (kind),
		.fired_handler (fired_handler),
		.alarm_armed   (alarm_armed),
		.alarm_delay   (alarm_delay),
		.last          (last)
	);

endmodule

// ----- rtl/dat_dpath.sv -----
// Datapath: slot memories, scan engine, delay calculation, config and result registers.
module dat_dpath import dat_pkg::*; #(
	parameter int SLOTS        = DEF_SLOTS,
	parameter int TIME_BITS    = DEF_TIME_BITS,
	parameter int HANDLER_BITS = DEF_HANDLER_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_W-1:0]        cfg_wdata,
	input  logic [TIME_BITS-1:0]    deadline,
	input  logic [HANDLER_BITS-1:0] handler_id,
	input  logic [TIME_BITS-1:0]    now_time,
	input  cmd_t                    cmd,
	output sts_t                    sts,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic [KIND_W-1:0]       kind,
	output logic [HANDLER_BITS-1:0] fired_handler,
	output logic                    alarm_armed,
	output logic [TIME_BITS-1:0]    alarm_delay,
	output logic                    last
);

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam logic [CNT_W-1:0] CNT_END = CNT_W'(SLOTS);

	// request registers
	logic [TIME_BITS-1:0]    req_dl_q;
	logic [HANDLER_BITS-1:0] req_hid_q;
	logic [TIME_BITS-1:0]    req_now_q;
	logic [CFG_W-1:0]        pdd_q;

	// slot storage
	logic [TIME_BITS-1:0]    dl_mem [SLOTS];
	logic [HANDLER_BITS-1:0] hd_mem [SLOTS];
	logic [SLOTS-1:0]        occ_q;

	// scan engine
	logic                    run_q;
	logic [CNT_W-1:0]        cnt_q;
	scan_mode_t              mode_q;
	logic                    rd_en;
	logic [IDX_W-1:0]        rd_idx;
	logic                    rd_v_s1;
	logic [IDX_W-1:0]        idx_s1;
	logic [TIME_BITS-1:0]    dl_s1;
	logic [HANDLER_BITS-1:0] hd_s1;
	logic                    occ_s1;
	logic                    hit_q;
	logic [IDX_W-1:0]        best_idx_q;
	logic [TIME_BITS-1:0]    best_dl_q;
	logic [HANDLER_BITS-1:0] best_hd_q;
	logic                    lt_now;
	logic                    lt_best;
	logic                    eq_req;
	logic                    take;
	logic                    scan_done;
	logic                    do_write;

	// results
	logic [TIME_BITS:0]      dly_sum;
	logic                    out_valid_q;
	kind_t                   out_kind_q;
	logic [HANDLER_BITS-1:0] out_hnd_q;
	logic                    armed_q;
	logic [TIME_BITS-1:0]    delay_q;
	logic                    out_armed_q;
	logic [TIME_BITS-1:0]    out_delay_q;
	logic                    out_last_q;

	assign rd_en     = run_q && (cnt_q != CNT_END);
	assign rd_idx    = cnt_q[IDX_W-1:0];
	assign scan_done = run_q && !rd_en && !rd_v_s1;
	assign do_write  = cmd.write_slot && (req_dl_q != '0);

	assign sts.scan_done = scan_done;
	assign sts.scan_hit  = hit_q;
	assign sts.can_emit  = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_dl_q  <= deadline;
			req_hid_q <= handler_id;
			req_now_q <= now_time;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pdd_q <= PAST_DUE_RESET;
		end else if (cfg_we) begin
			pdd_q <= cfg_wdata;
		end
	end

	// a zero deadline on insert leaves the slot free, so nothing is written
	always_ff @(posedge clk) begin
		if (do_write) begin
			dl_mem[best_idx_q] <= req_dl_q;
			hd_mem[best_idx_q] <= req_hid_q;
		end
		if (rd_en) begin
			dl_s1  <= dl_mem[rd_idx];
			hd_s1  <= hd_mem[rd_idx];
			occ_s1 <= occ_q[rd_idx];
		end
		idx_s1 <= rd_idx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			if (do_write) begin
				occ_q[best_idx_q] <= 1'b1;
			end
			if (cmd.clear_slot) begin
				occ_q[best_idx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			cnt_q   <= '0;
			rd_v_s1 <= 1'b0;
			mode_q  <= SC_MIN_ALL;
		end else begin
			rd_v_s1 <= rd_en;
			if (rd_en) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (scan_done) begin
				run_q <= 1'b0;
			end
			if (cmd.scan_start) begin
				run_q  <= 1'b1;
				cnt_q  <= '0;
				mode_q <= cmd.scan_mode;
			end
		end
	end

	assign lt_now  = dl_s1 < req_now_q;
	assign lt_best = dl_s1 < best_dl_q;
	assign eq_req  = (dl_s1 == req_dl_q) && (hd_s1 == req_hid_q);

	// first-hit searches keep the lowest slot; minimum searches replace on strictly less
	always_comb begin
		unique case (mode_q)
			SC_FREE:     take = !hit_q && !occ_s1;
			SC_MATCH:    take = !hit_q && occ_s1 && eq_req;
			SC_MIN_ALL:  take = occ_s1 && (!hit_q || lt_best);
			SC_MIN_LIVE: take = occ_s1 && !lt_now && (!hit_q || lt_best);
			SC_DUE:      take = occ_s1 && lt_now && (!hit_q || lt_best);
			default:     take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (cmd.scan_start) begin
			hit_q <= 1'b0;
		end else if (rd_v_s1 && take) begin
			hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_v_s1 && take) begin
			best_idx_q <= idx_s1;
			best_dl_q  <= dl_s1;
			best_hd_q  <= hd_s1;
		end
	end

	// earliest minus now plus one; the carry out means saturation
	assign dly_sum = {1'b0, best_dl_q} - {1'b0, req_now_q} + {{TIME_BITS{1'b0}}, 1'b1};

	always_ff @(posedge clk) begin
		if (cmd.calc_delay) begin
			armed_q <= hit_q;
			if (!hit_q) begin
				delay_q <= '0;
			end else if (req_now_q < best_dl_q) begin
				delay_q <= dly_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : dly_sum[TIME_BITS-1:0];
			end else begin
				delay_q <= TIME_BITS'(pdd_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_kind_q  <= cmd.emit_kind;
			out_hnd_q   <= (cmd.emit_kind == KIND_FIRED) ? best_hd_q : '0;
			out_armed_q <= armed_q;
			out_delay_q <= delay_q;
			out_last_q  <= cmd.emit_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = out_kind_q;
	assign fired_handler = out_hnd_q;
	assign alarm_armed   = out_armed_q;
	assign alarm_delay   = out_delay_q;
	assign last          = out_last_q;

	a_clear_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear_slot |-> occ_q[best_idx_q])
		else $error("clearing a free slot");

	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_slot |-> !occ_q[best_idx_q])
		else $error("insert into an occupied slot");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_start |-> (!run_q || scan_done))
		else $error("scan started while another is running");

	a_done_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_done && !cmd.scan_start) |=> !run_q)
		else $error("scan still running after done");

endmodule

// ----- rtl/dat_ctrl.sv -----
// Controller: sequences scans, table updates and result emission per request.
module dat_ctrl import dat_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [ACTION_W-1:0] action,
	input  sts_t                sts,
	output cmd_t                cmd
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_FREE  = 8'b0000_0010,
		S_MATCH = 8'b0000_0100,
		S_MIN   = 8'b0000_1000,
		S_DLY   = 8'b0001_0000,
		S_DUE   = 8'b0010_0000,
		S_FIRE  = 8'b0100_0000,
		S_FIN   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   chk_q, chk_d;
	kind_t  kind_q, kind_d;

	always_comb begin
		state_d  = state_q;
		chk_d    = chk_q;
		kind_d   = kind_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load       = 1'b1;
					cmd.scan_start = 1'b1;
					kind_d         = KIND_UPDATE;
					chk_d          = (action == ACT_CHECK);
					unique case (action)
						ACT_INSERT: begin
							cmd.scan_mode = SC_FREE;
							state_d       = S_FREE;
						end
						ACT_CANCEL: begin
							cmd.scan_mode = SC_MATCH;
							state_d       = S_MATCH;
						end
						// entries already due are left out: they fire before the update
						ACT_CHECK: begin
							cmd.scan_mode = SC_MIN_LIVE;
							state_d       = S_MIN;
						end
						default: begin
							cmd.scan_mode = SC_MIN_ALL;
							state_d       = S_MIN;
						end
					endcase
				end
			end
			S_FREE: begin
				if (sts.scan_done) begin
					cmd.write_slot = sts.scan_hit;
					kind_d         = sts.scan_hit ? KIND_UPDATE : KIND_FULL;
					cmd.scan_start = 1'b1;
					cmd.scan_mode  = SC_MIN_ALL;
					state_d        = S_MIN;
				end
			end
			S_MATCH: begin
				if (sts.scan_done) begin
					cmd.clear_slot = sts.scan_hit;
					kind_d         = sts.scan_hit ? KIND_UPDATE : KIND_NOTFOUND;
					cmd.scan_start = 1'b1;
					cmd.scan_mode  = SC_MIN_ALL;
					state_d        = S_MIN;
				end
			end
			S_MIN: begin
				if (sts.scan_done) begin
					state_d = S_DLY;
				end
			end
			S_DLY: begin
				cmd.calc_delay = 1'b1;
				if (chk_q) begin
					cmd.scan_start = 1'b1;
					cmd.scan_mode  = SC_DUE;
					state_d        = S_DUE;
				end else begin
					state_d = S_FIN;
				end
			end
			S_DUE: begin
				if (sts.scan_done) begin
					state_d = sts.scan_hit ? S_FIRE : S_FIN;
				end
			end
			S_FIRE: begin
				if (sts.can_emit) begin
					cmd.emit       = 1'b1;
					cmd.emit_kind  = KIND_FIRED;
					cmd.clear_slot = 1'b1;
					cmd.scan_start = 1'b1;
					cmd.scan_mode  = SC_DUE;
					state_d        = S_DUE;
				end
			end
			S_FIN: begin
				if (sts.can_emit) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = kind_q;
					cmd.emit_last = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			chk_q   <= 1'b0;
			kind_q  <= KIND_UPDATE;
		end else begin
			state_q <= state_d;
			chk_q   <= chk_d;
			kind_q  <= kind_d;
		end
	end

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.can_emit)
		else $error("result emitted into a full output register");

	a_scan_not_instant: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_start |=> !sts.scan_done)
		else $error("scan reported done right after start");

	a_last_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.emit_last) |=> in_ready)
		else $error("not ready for a new request after the final result");

endmodule

// ----- tb/deadline_alarm_table_test.sv -----
// Self-checking testbench for deadline_alarm_table: table predictor, bursty requests, stalled results.
module deadline_alarm_table_test;
	import dat_pkg::*;

	localparam int SLOTS = DEF_SLOTS;
	localparam int TW    = DEF_TIME_BITS;
	localparam int HW    = DEF_HANDLER_BITS;
	localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;	// decodes as a request that changes nothing and fires nothing
	localparam logic [TW-1:0] TIME_MAX = '1;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 29;
	localparam int FILL_PHASE  = 3;

	typedef struct {
		logic [ACTION_W-1:0] action;
		logic [TW-1:0]       deadline;
		logic [HW-1:0]       handler;
		logic [TW-1:0]       now;
	} alarm_request_t;

	typedef struct {
		kind_t         kind;
		logic [HW-1:0] handler;
		logic          armed;
		logic [TW-1:0] delay;
		logic          last;
	} alarm_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CFG_W-1:0]    cfg_wdata = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [ACTION_W-1:0] action = '0;
	logic [TW-1:0]       deadline = '0;
	logic [HW-1:0]       handler_id = '0;
	logic [TW-1:0]       now_time = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [KIND_W-1:0]   kind;
	logic [HW-1:0]       fired_handler;
	logic                alarm_armed;
	logic [TW-1:0]       alarm_delay;
	logic                last;

	deadline_alarm_table dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.deadline     (deadline),
		.handler_id   (handler_id),
		.now_time     (now_time),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.fired_handler(fired_handler),
		.alarm_armed  (alarm_armed),
		.alarm_delay  (alarm_delay),
		.last         (last)
	);

	// predicted table contents
	logic [TW-1:0]    table_deadline [SLOTS];
	logic [HW-1:0]    table_handler [SLOTS];
	logic [CFG_W-1:0] past_due_setting = PAST_DUE_RESET;

	alarm_request_t pending_requests [$];
	alarm_result_t  expected_results [$];
	alarm_request_t armed_history [$];	// inserted alarms, used to aim cancels
	alarm_request_t live_req;
	alarm_result_t  want;
	logic [TW-1:0]  clock_now = '0;
	int             mismatch_count = 0;
	int             burst_left = 0;
	int             send_gap = 0;
	int             stall_tick = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("deadline_alarm_table regression: fail");
		$finish;
	end

	function automatic int earliest_slot();
		int best;
		best = -1;
		for (int i = 0; i < SLOTS; i++)
			if (table_deadline[i] != '0 &&
			    (best < 0 || table_deadline[i] < table_deadline[best]))
				best = i;
		return best;
	endfunction

	// Update the predicted table for one accepted request and queue its results.
	task automatic apply_request(input alarm_request_t r);
		logic [HW-1:0] fired [$];
		kind_t         outcome;
		logic          armed;
		logic [TW-1:0] delay;
		logic [TW-1:0] lead;
		int            e;
		bit            done;
		alarm_result_t res;
		outcome = KIND_UPDATE;
		done = 1'b0;
		case (r.action)
			ACT_INSERT: begin
				outcome = KIND_FULL;
				for (int i = 0; i < SLOTS && !done; i++)
					if (table_deadline[i] == '0) begin
						table_deadline[i] = r.deadline;
						table_handler[i] = r.handler;
						outcome = KIND_UPDATE;
						done = 1'b1;
					end
			end
			ACT_CANCEL: begin
				outcome = KIND_NOTFOUND;
				// zero deadline would only match free slots, which never count
				for (int i = 0; i < SLOTS && !done; i++)
					if (r.deadline != '0 && table_deadline[i] == r.deadline &&
					    table_handler[i] == r.handler) begin
						table_deadline[i] = '0;
						outcome = KIND_UPDATE;
						done = 1'b1;
					end
			end
			ACT_CHECK: begin
				e = earliest_slot();
				while (e >= 0 && table_deadline[e] < r.now) begin
					fired.push_back(table_handler[e]);
					table_deadline[e] = '0;
					e = earliest_slot();
				end
			end
			default: ;
		endcase
		e = earliest_slot();
		armed = (e >= 0);
		delay = '0;
		if (armed) begin
			if (r.now < table_deadline[e]) begin
				lead = table_deadline[e] - r.now;
				delay = (lead == TIME_MAX) ? TIME_MAX : lead + TW'(1);
			end else
				delay = TW'(past_due_setting);
		end
		foreach (fired[j]) begin
			res = '{KIND_FIRED, fired[j], armed, delay, 1'b0};
			expected_results.push_back(res);
		end
		res = '{outcome, '0, armed, delay, 1'b1};
		expected_results.push_back(res);
	endtask

	task automatic log_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t mismatch: %s", $time, msg);
	endtask

	function automatic logic [TW-1:0] random_time();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[TW-1:0];
	endfunction

	function automatic logic [TW-1:0] pick_deadline();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return clock_now + TW'($urandom_range(0, 3000)) - TW'(500);
		if (roll < 82 && armed_history.size() > 0)
			return armed_history[$urandom_range(0, armed_history.size() - 1)].deadline;
		if (roll < 85)
			return '0;
		return random_time();
	endfunction

	task automatic queue_request(input logic [ACTION_W-1:0] a, input logic [TW-1:0] dl,
	                             input logic [HW-1:0] h, input logic [TW-1:0] t);
		alarm_request_t r;
		r = '{a, dl, h, t};
		pending_requests.push_back(r);
		if (a == ACT_INSERT && dl != '0) begin
			armed_history.push_back(r);
			if (armed_history.size() > 64)
				armed_history.delete(0);
		end
	endtask

	// Mostly insert bursts, cancels and checks around a slowly advancing clock, plus noise.
	task automatic queue_random_phase(input bit fill_first);
		int             count;
		int             burst;
		int unsigned    roll;
		alarm_request_t target;
		count = 0;
		if (fill_first) begin
			// overfill, then fire the whole table in one check
			for (int i = 0; i < SLOTS + 2; i++)
				queue_request(ACT_INSERT, clock_now + TW'($urandom_range(1, 4000)),
				              HW'($urandom()), clock_now);
			queue_request(ACT_CHECK, random_time(), HW'($urandom()), TIME_MAX);
			count = SLOTS + 3;
		end
		while (count < PHASE_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 45) begin
				burst = $urandom_range(1, 8);
				for (int i = 0; i < burst; i++)
					queue_request(ACT_INSERT, pick_deadline(), HW'($urandom()),
					              ($urandom_range(0, 9) == 0) ? random_time() : clock_now);
				count += burst;
			end else if (roll < 65) begin
				burst = $urandom_range(1, 3);
				for (int i = 0; i < burst; i++) begin
					if (armed_history.size() > 0 && $urandom_range(0, 3) != 0) begin
						target = armed_history[$urandom_range(0, armed_history.size() - 1)];
						queue_request(ACT_CANCEL, target.deadline, target.handler, clock_now);
					end else
						queue_request(ACT_CANCEL, pick_deadline(), HW'($urandom()), clock_now);
				end
				count += burst;
			end else if (roll < 92) begin
				roll = $urandom_range(0, 9);
				if (roll == 0)
					queue_request(ACT_CHECK, random_time(), HW'($urandom()), random_time());
				else if (roll == 1)
					queue_request(ACT_CHECK, random_time(), HW'($urandom()),
					              clock_now - TW'($urandom_range(0, 1000)));
				else begin
					clock_now = clock_now + TW'($urandom_range(0, 2500));
					queue_request(ACT_CHECK, random_time(), HW'($urandom()), clock_now);
				end
				count++;
			end else begin
				queue_request(ACTION_W'($urandom_range(0, 3)), random_time(), HW'($urandom()),
				              random_time());
				count++;
			end
		end
	endtask

	task automatic wait_idle(input int tail);
		do
			@(posedge clk);
		while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (tail) @(posedge clk);
	endtask

	// request driver: bursts of random length separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready)
				apply_request(live_req);
			if (!in_valid || in_ready) begin
				if (send_gap > 0 || pending_requests.size() == 0) begin
					if (send_gap > 0)
						send_gap--;
					in_valid <= 1'b0;
				end else begin
					live_req = pending_requests.pop_front();
					action <= live_req.action;
					deadline <= live_req.deadline;
					handler_id <= live_req.handler;
					now_time <= live_req.now;
					in_valid <= 1'b1;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						send_gap = $urandom_range(1, 12);
						burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 8);
					end
				end
			end
		end
	end

	// result monitor; ready pattern rotates between open, random, sparse and long stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_tick = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0)
					log_mismatch($sformatf(
						"unexpected result kind %0d handler %0h armed %0b delay %0h last %0b",
						kind, fired_handler, alarm_armed, alarm_delay, last));
				else begin
					want = expected_results.pop_front();
					if (kind !== want.kind || fired_handler !== want.handler ||
					    alarm_armed !== want.armed || alarm_delay !== want.delay ||
					    last !== want.last)
						log_mismatch($sformatf({"expected kind %0d handler %0h armed %0b ",
							"delay %0h last %0b, got kind %0d handler %0h armed %0b ",
							"delay %0h last %0b"},
							want.kind, want.handler, want.armed, want.delay, want.last,
							kind, fired_handler, alarm_armed, alarm_delay, last));
				end
			end
			stall_tick++;
			case ((stall_tick / 97) % 4)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= (stall_tick % 4 == 0);
				default: out_ready <= (stall_tick % 16 == 0);
			endcase
		end
	end

	initial begin
		logic [CFG_W-1:0] setting;
		for (int i = 0; i < SLOTS; i++) begin
			table_deadline[i] = '0;
			table_handler[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty table, saturation, zero deadlines, ties, past due
		queue_request(ACT_CHECK, '0, '0, '0);
		queue_request(ACT_INSERT, TIME_MAX, 8'hFF, '0);
		queue_request(ACT_INSERT, TW'(1), '0, '0);
		queue_request(ACT_INSERT, '0, 8'hAA, '0);
		queue_request(ACT_CANCEL, '0, 8'hAA, '0);
		queue_request(ACT_CANCEL, TW'(1), 8'h05, '0);
		queue_request(ACT_CANCEL, TW'(1), '0, '0);
		queue_request(ACT_SPARE, random_time(), HW'($urandom()), TIME_MAX);
		queue_request(ACT_INSERT, TW'(5), 8'h01, TW'(2));
		queue_request(ACT_INSERT, TW'(5), 8'h02, TW'(2));
		queue_request(ACT_INSERT, TW'(3), 8'h03, TW'(4));
		queue_request(ACT_INSERT, 48'h8000_0000_0000, 8'h80, TW'(2));
		queue_request(ACT_CHECK, '0, '0, TW'(5));
		queue_request(ACT_CHECK, '0, '0, TW'(6));
		queue_request(ACT_CANCEL, TIME_MAX, 8'hFF, TW'(6));
		queue_request(ACT_CHECK, TIME_MAX, 8'hFF, TIME_MAX);
		queue_request(ACT_CHECK, '0, '0, '0);
		queue_request(ACT_INSERT, 48'h5555_5555_5555, 8'h55, 48'hAAAA_AAAA_AAAA);
		queue_request(ACT_INSERT, 48'hAAAA_AAAA_AAAA, 8'hAA, 48'h5555_5555_5555);
		queue_request(ACT_CHECK, '0, '0, TIME_MAX);
		wait_idle(80);

		clock_now = TW'($urandom_range(1 << 20, 32'hFFFF_FFFF)) << $urandom_range(0, 8);
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: setting = CFG_W'(1);
				1: setting = CFG_W'(1000000);
				2: setting = '0;
				FILL_PHASE: setting = '1;
				default: setting = CFG_W'($urandom_range(1, 1000000));
			endcase
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_wdata <= setting;
			past_due_setting = setting;
			@(posedge clk);
			cfg_we <= 1'b0;
			queue_random_phase(p == FILL_PHASE);
			wait_idle(p == PHASES - 1 ? 120 : 80);
		end

		if (mismatch_count == 0)
			$display("deadline_alarm_table regression: pass");
		else
			$display("deadline_alarm_table regression: fail");
		$finish;
	end

endmodule
